@@ hdl/inu_pkg.sv @@
// inu_pkg: shared widths, register indexes, sequencer states and pixel
// format helper for the integer nearest upscaler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package inu_pkg;

  localparam int MAX_SCALE_DEF     = 8;
  localparam int MAX_DIMENSION_DEF = 4096;

  localparam int DIM_W      = 13;
  localparam int PITCH_W    = 14;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int SRC_PIX_W  = 32;
  localparam int PIXEL_W    = 24;
  localparam int OFFSET_W   = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_PANEL_WIDTH     = 3'd2,
    CFG_PANEL_HEIGHT    = 3'd3,
    CFG_ROW_PITCH_WORDS = 3'd4,
    CFG_SWAP_RED_BLUE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_START,
    ST_BASE,
    ST_WRITE,
    ST_ERROR
  } state_t;

  function automatic logic [PIXEL_W-1:0] to_xrgb(input logic [SRC_PIX_W-1:0] p,
                                                 input logic swap);
    logic [PIXEL_W-1:0] r;
    if (swap) begin
      r = {p[7:0], p[15:8], p[23:16]};
    end else begin
      r = p[PIXEL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/inu_if.sv @@
// inu_if: valid/ready channel interfaces for source pixels and buffer writes
// depends on inu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface inu_pix_if;
  import inu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SRC_PIX_W-1:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink (input valid, input source_pixel, output ready);
endinterface

interface inu_wr_if;
  import inu_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] dest_offset;
  logic [PIXEL_W-1:0]  out_pixel;
  logic                scale_error;
  logic                last;

  modport source (output valid, output dest_offset, output out_pixel,
                  output scale_error, output last, input ready);
  modport sink (input valid, input dest_offset, input out_pixel,
                input scale_error, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/integer_nearest_upscaler.sv @@
// integer_nearest_upscaler: writes each source pixel as a scale x scale block
// of words into a centred scanout buffer, one write per cycle while writes.ready holds
// depends on inu_pkg, inu_if
//
// channel   dir  handshake        item
// pixels    in   valid/ready      source_pixel
// writes    out  valid/ready      dest_offset, out_pixel, scale_error, last
// cfg       in   cfg_we only      cfg_index, cfg_data
//
// one item goes through idle, search, start, base and write states, scale <= MAX_SCALE;
// the scale search steps one shared add/compare per cycle, then one write a cycle unless writes is held
// a frame that does not fit goes through idle, search and error and gives one error item
// pixels.ready is high only between items; a held write stalls the sequencer
// synchronous active-high reset sets config registers to 1, position to 0 and state to idle
`timescale 1ns / 1ps
`default_nettype none

module integer_nearest_upscaler
  import inu_pkg::*;
#(
  parameter int MAX_SCALE     = MAX_SCALE_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  inu_pix_if.sink               pixels,
  inu_wr_if.source              writes
);

  localparam int POS_W   = $clog2(MAX_DIMENSION);
  localparam int SCALE_W = $clog2(MAX_SCALE + 1);
  localparam int ACC_W   = DIM_W + 1;
  localparam int PROD_W  = POS_W + SCALE_W;
  localparam int START_W = ((PROD_W > DIM_W - 1) ? PROD_W : DIM_W - 1) + 1;
  localparam int MUL_W   = START_W + PITCH_W;
  localparam logic [DIM_W:0]     DIM_LIMIT   = (DIM_W + 1)'(MAX_DIMENSION);
  localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(MAX_SCALE);

  // configuration
  logic [DIM_W-1:0]   frame_width, frame_height, panel_width, panel_height;
  logic [PITCH_W-1:0] row_pitch_words;
  logic               swap_red_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= DIM_W'(1);
      frame_height    <= DIM_W'(1);
      panel_width     <= DIM_W'(1);
      panel_height    <= DIM_W'(1);
      row_pitch_words <= PITCH_W'(1);
      swap_red_blue   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[DIM_W-1:0];
        CFG_PANEL_WIDTH:     panel_width     <= cfg_data[DIM_W-1:0];
        CFG_PANEL_HEIGHT:    panel_height    <= cfg_data[DIM_W-1:0];
        CFG_ROW_PITCH_WORDS: row_pitch_words <= cfg_data[PITCH_W-1:0];
        CFG_SWAP_RED_BLUE:   swap_red_blue   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [DIM_W-1:0] fw, fh;
  assign fw = ({1'b0, frame_width} > DIM_LIMIT) ? DIM_LIMIT[DIM_W-1:0] : frame_width;
  assign fh = ({1'b0, frame_height} > DIM_LIMIT) ? DIM_LIMIT[DIM_W-1:0] : frame_height;

  state_t state, state_next;

  logic [POS_W-1:0]    source_column, source_row;
  logic [POS_W-1:0]    cur_col, cur_row;
  logic [PIXEL_W-1:0]  pix;
  logic [SCALE_W-1:0]  scale;
  logic [ACC_W-1:0]    acc_w, acc_h;
  logic [START_W-1:0]  x_start, y_start;
  logic [OFFSET_W-1:0] line_base, wr_off;
  logic [SCALE_W-1:0]  dx, dy;

  logic                res_valid;
  logic [OFFSET_W-1:0] res_offset;
  logic [PIXEL_W-1:0]  res_pixel;
  logic                res_error, res_last;

  // shared add/compare for the scale search
  logic [ACC_W-1:0] cand_w, cand_h;
  logic             fit;
  assign cand_w = acc_w + ACC_W'(fw);
  assign cand_h = acc_h + ACC_W'(fh);
  assign fit = (fw != '0) && (fh != '0) && (cand_w <= ACC_W'(panel_width)) &&
               (cand_h <= ACC_W'(panel_height)) && (scale != SCALE_LIMIT);

  logic              accept, slot_free, block_end, row_end;
  logic [SCALE_W-1:0] scale_m1;
  assign accept    = pixels.valid && pixels.ready;
  assign slot_free = !res_valid || writes.ready;
  assign scale_m1  = scale - SCALE_W'(1);
  assign row_end   = (dx == scale_m1);
  assign block_end = row_end && (dy == scale_m1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (pixels.valid) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (!fit) state_next = (scale == '0) ? ST_ERROR : ST_START;
      end
      ST_START:  state_next = ST_BASE;
      ST_BASE:   state_next = ST_WRITE;
      ST_WRITE:  if (slot_free && block_end) state_next = ST_IDLE;
      ST_ERROR:  if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  logic load_write, load_error;
  always_comb begin
    pixels.ready = 1'b0;
    load_write   = 1'b0;
    load_error   = 1'b0;
    unique case (state)
      ST_IDLE:  pixels.ready = 1'b1;
      ST_WRITE: load_write   = slot_free;
      ST_ERROR: load_error   = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // source position
  logic [DIM_W:0] col_inc, row_inc;
  assign col_inc = (DIM_W + 1)'(source_column) + (DIM_W + 1)'(1);
  assign row_inc = (DIM_W + 1)'(source_row) + (DIM_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
    end else if (accept) begin
      if (col_inc >= (DIM_W + 1)'(fw)) begin
        source_column <= '0;
        source_row    <= (row_inc >= (DIM_W + 1)'(fh)) ? '0 : row_inc[POS_W-1:0];
      end else begin
        source_column <= col_inc[POS_W-1:0];
      end
    end
  end

  // datapath
  logic [DIM_W-1:0]   x0_full, y0_full;
  logic [MUL_W-1:0]   base_prod;
  assign x0_full   = panel_width - acc_w[DIM_W-1:0];
  assign y0_full   = panel_height - acc_h[DIM_W-1:0];
  assign base_prod = MUL_W'(y_start) * MUL_W'(row_pitch_words);

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col <= source_column;
      cur_row <= source_row;
      pix     <= to_xrgb(pixels.source_pixel, swap_red_blue);
      scale   <= '0;
      acc_w   <= '0;
      acc_h   <= '0;
    end
    if (state == ST_SEARCH && fit) begin
      scale <= scale + SCALE_W'(1);
      acc_w <= cand_w;
      acc_h <= cand_h;
    end
    if (state == ST_START) begin
      x_start <= START_W'(x0_full >> 1) + START_W'(cur_col) * START_W'(scale);
      y_start <= START_W'(y0_full >> 1) + START_W'(cur_row) * START_W'(scale);
    end
    if (state == ST_BASE) begin
      line_base <= base_prod[OFFSET_W-1:0] + OFFSET_W'(x_start);
      wr_off    <= base_prod[OFFSET_W-1:0] + OFFSET_W'(x_start);
      dx        <= '0;
      dy        <= '0;
    end
    if (load_write) begin
      if (row_end) begin
        dx        <= '0;
        dy        <= dy + SCALE_W'(1);
        line_base <= line_base + OFFSET_W'(row_pitch_words);
        wr_off    <= line_base + OFFSET_W'(row_pitch_words);
      end else begin
        dx     <= dx + SCALE_W'(1);
        wr_off <= wr_off + OFFSET_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_write || load_error) begin
      res_valid <= 1'b1;
    end else if (writes.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_write) begin
      res_offset <= wr_off;
      res_pixel  <= pix;
      res_error  <= 1'b0;
      res_last   <= block_end;
    end else if (load_error) begin
      res_offset <= '0;
      res_pixel  <= '0;
      res_error  <= 1'b1;
      res_last   <= 1'b1;
    end
  end

  assign writes.valid       = res_valid;
  assign writes.dest_offset = res_offset;
  assign writes.out_pixel   = res_pixel;
  assign writes.scale_error = res_error;
  assign writes.last        = res_last;

endmodule

`default_nettype wire

@@ hdl/inu_checker.sv @@
// inu_checker: port-level assertions for integer_nearest_upscaler, bound to it
// depends on inu_pkg and integer_nearest_upscaler
`timescale 1ns / 1ps
`default_nettype none

module inu_checker
  import inu_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OFFSET_W-1:0] dest_offset,
  input logic [PIXEL_W-1:0]  out_pixel,
  input logic                scale_error,
  input logic                last
);

  // a held item keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dest_offset) &&
      $stable(out_pixel) && $stable(scale_error) && $stable(last))
    else $error("write item changed while stalled");

  // an error item is alone and empty
  a_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && scale_error |-> last && dest_offset == '0 && out_pixel == '0)
    else $error("error item malformed");

  // one item in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no new pixel until the block of writes is complete
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready mid block");

endmodule

bind integer_nearest_upscaler inu_checker u_inu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixels.valid),
  .in_ready    (pixels.ready),
  .out_valid   (writes.valid),
  .out_ready   (writes.ready),
  .dest_offset (writes.dest_offset),
  .out_pixel   (writes.out_pixel),
  .scale_error (writes.scale_error),
  .last        (writes.last)
);

`default_nettype wire
